// ===== sv/lpr_pkg.sv =====
// ----------------------------------------------------------------------------
// lpr_pkg: shared types and constants
// Frame count, widths, controller states and the scan result record used by
// the page replacement engine.
// ----------------------------------------------------------------------------
package lpr_pkg;

  // frame store geometry
  localparam int unsigned FRAMES    = 16;
  localparam int unsigned PAGE_BITS = 16;
  localparam int unsigned IDX_W     = $clog2(FRAMES);
  localparam int unsigned RANK_W    = IDX_W;

  // frames-in-use register and fault counter
  localparam int unsigned LIMIT_W   = 5;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(3);
  localparam int unsigned FAULT_W   = 32;

  // controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_LAST,
    ST_DECIDE,
    ST_UPD,
    ST_UPD_LAST
  } lpr_state_e;

  // what the lookup scan has found so far
  typedef struct packed {
    logic                 found;
    logic [IDX_W-1:0]     found_idx;
    logic [RANK_W-1:0]    found_rank;
    logic                 empty;
    logic [IDX_W-1:0]     empty_idx;
    logic                 victim;
    logic [IDX_W-1:0]     victim_idx;
    logic [RANK_W-1:0]    victim_rank;
    logic [PAGE_BITS-1:0] victim_page;
  } scan_res_t;

endpackage

// ===== sv/lpr_ram.sv =====
// ----------------------------------------------------------------------------
// lpr_ram: simple dual-port synchronous RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module lpr_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/lpr_scan.sv =====
// ----------------------------------------------------------------------------
// lpr_scan: lookup scan accumulator
// Takes one frame per cycle while en_i is set, as it returns from the stores,
// and keeps the first matching, first empty and least recently used frame.
// ----------------------------------------------------------------------------
module lpr_scan (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           clr_i,
  input  logic                           en_i,
  input  logic [lpr_pkg::IDX_W-1:0]      idx_i,
  input  logic                           valid_i,
  input  logic                           match_i,
  input  logic [lpr_pkg::RANK_W-1:0]     rank_i,
  input  logic [lpr_pkg::PAGE_BITS-1:0]  page_i,
  output lpr_pkg::scan_res_t             res_o
);
  import lpr_pkg::*;

  scan_res_t res_d, res_q;

  // fold one frame into the running result
  always_comb begin
    res_d = res_q;
    if (clr_i) begin
      res_d.found  = 1'b0;
      res_d.empty  = 1'b0;
      res_d.victim = 1'b0;
    end else if (en_i) begin
      if (valid_i) begin
        if (!res_q.found && match_i) begin
          res_d.found      = 1'b1;
          res_d.found_idx  = idx_i;
          res_d.found_rank = rank_i;
        end
        // oldest wins, first frame on a tie
        if (!res_q.victim || (rank_i > res_q.victim_rank)) begin
          res_d.victim      = 1'b1;
          res_d.victim_idx  = idx_i;
          res_d.victim_rank = rank_i;
          res_d.victim_page = page_i;
        end
      end else if (!res_q.empty) begin
        res_d.empty     = 1'b1;
        res_d.empty_idx = idx_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_q <= '0;
    end else begin
      res_q <= res_d;
    end
  end

  assign res_o = res_q;

endmodule

// ===== sv/lru_page_replacement.sv =====
// ----------------------------------------------------------------------------
// lru_page_replacement: LRU page frame replacement engine
// Sequence after start is taken (L = clamped frames in use): L scan reads,
// one drain, one decision, a 16-entry rank sweep and a final write; done_o
// pulses in the same cycle that busy falls. No new word is taken while busy,
// so each word waits for the sequential frame scan and the rank sweep.
// The receiver cannot stall; results are never held back.
// Reset clears valid bits, fault count and control; stores need no clearing.
// ----------------------------------------------------------------------------
module lru_page_replacement (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           frames_in_use_we_i,
  input  logic [lpr_pkg::LIMIT_W-1:0]    frames_in_use_i,
  input  logic                           start,
  output logic                           busy,
  input  logic [lpr_pkg::PAGE_BITS-1:0]  page_number_i,
  output logic                           done_o,
  output logic                           hit_o,
  output logic [lpr_pkg::IDX_W-1:0]      frame_index_o,
  output logic                           evicted_valid_o,
  output logic [lpr_pkg::PAGE_BITS-1:0]  evicted_page_o,
  output logic [lpr_pkg::FAULT_W-1:0]    fault_count_o
);
  import lpr_pkg::*;

  lpr_state_e state_q, state_d;

  logic [LIMIT_W-1:0]   limit_cfg_q;
  logic [LIMIT_W-1:0]   limit;
  logic [LIMIT_W-1:0]   limit_m1;
  logic [PAGE_BITS-1:0] page_q;
  logic [IDX_W-1:0]     idx_q, idx_d;
  logic                 rd_vld_q;
  logic [IDX_W-1:0]     rd_idx_q;
  logic [FRAMES-1:0]    valid_q;
  logic [FAULT_W-1:0]   fault_q;
  logic [IDX_W-1:0]     target_q;
  logic [RANK_W-1:0]    old_rank_q;
  logic                 age_all_q;
  logic                 hit_q;
  logic                 ev_valid_q;
  logic [PAGE_BITS-1:0] ev_page_q;
  logic                 done_q;

  logic                 accept;
  logic                 issue;
  logic                 scan_en;
  logic                 sweep_en;
  logic                 last_issue;
  logic [PAGE_BITS-1:0] page_rd;
  logic [RANK_W-1:0]    rank_rd;
  logic                 page_we;
  logic                 rank_we;
  logic [RANK_W-1:0]    rank_wdata;
  logic                 rd_frame_valid;
  logic [IDX_W-1:0]     target_d;
  scan_res_t            scan_res;

  assign accept = start && !busy;

  // frames-in-use register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_cfg_q <= LIMIT_RESET;
    end else if (frames_in_use_we_i) begin
      limit_cfg_q <= frames_in_use_i;
    end
  end

  // clamp limit to 1 .. FRAMES
  always_comb begin
    limit = limit_cfg_q;
    if (limit_cfg_q == '0) begin
      limit = LIMIT_W'(1);
    end else if (limit_cfg_q > LIMIT_W'(FRAMES)) begin
      limit = LIMIT_W'(FRAMES);
    end
  end
  assign limit_m1 = limit - LIMIT_W'(1);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:     if (accept) state_d = ST_SCAN;
      ST_SCAN:     if ({1'b0, idx_q} == limit_m1) state_d = ST_LAST;
      ST_LAST:     state_d = ST_DECIDE;
      ST_DECIDE:   state_d = ST_UPD;
      ST_UPD:      if (idx_q == IDX_W'(FRAMES - 1)) state_d = ST_UPD_LAST;
      ST_UPD_LAST: state_d = ST_IDLE;
      default:     state_d = ST_IDLE;
    endcase
  end

  // per-state controls
  always_comb begin
    issue      = 1'b0;
    scan_en    = 1'b0;
    sweep_en   = 1'b0;
    last_issue = 1'b0;
    idx_d      = idx_q;
    busy       = 1'b1;
    unique case (state_q)
      ST_IDLE: begin
        busy  = 1'b0;
        idx_d = '0;
      end
      ST_SCAN: begin
        issue      = 1'b1;
        scan_en    = rd_vld_q;
        last_issue = ({1'b0, idx_q} == limit_m1);
        idx_d      = last_issue ? '0 : idx_q + IDX_W'(1);
      end
      ST_LAST: begin
        scan_en = rd_vld_q;
      end
      ST_DECIDE: begin
        idx_d = '0;
      end
      ST_UPD: begin
        issue    = 1'b1;
        sweep_en = rd_vld_q;
        idx_d    = idx_q + IDX_W'(1);
      end
      ST_UPD_LAST: begin
        sweep_en = rd_vld_q;
      end
      default: begin
        busy = 1'b1;
      end
    endcase
  end

  // state, read pipeline tag and captured page
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      idx_q    <= '0;
      rd_vld_q <= 1'b0;
      rd_idx_q <= '0;
    end else begin
      state_q  <= state_d;
      idx_q    <= idx_d;
      rd_vld_q <= issue;
      rd_idx_q <= idx_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      page_q <= page_number_i;
    end
  end

  // frame chosen for this reference
  always_comb begin
    if (scan_res.found) begin
      target_d = scan_res.found_idx;
    end else if (scan_res.empty) begin
      target_d = scan_res.empty_idx;
    end else begin
      target_d = scan_res.victim_idx;
    end
  end

  // page store: read during scan, written with the new page on a fault
  assign page_we = (state_q == ST_DECIDE) && !scan_res.found;

  lpr_ram #(
    .WIDTH (PAGE_BITS),
    .DEPTH (FRAMES)
  ) u_page_ram (
    .clk_i   (clk_i),
    .we_i    (page_we),
    .waddr_i (target_d),
    .wdata_i (page_q),
    .re_i    (issue),
    .raddr_i (idx_q),
    .rdata_o (page_rd)
  );

  // rank store: read during scan and sweep, written back during sweep
  assign rd_frame_valid = valid_q[rd_idx_q];

  always_comb begin
    rank_wdata = rank_rd;
    if (rd_idx_q == target_q) begin
      rank_wdata = '0;
    end else if (age_all_q || (rank_rd < old_rank_q)) begin
      rank_wdata = rank_rd + RANK_W'(1);
    end
  end
  assign rank_we = sweep_en && (rd_frame_valid || (rd_idx_q == target_q));

  lpr_ram #(
    .WIDTH (RANK_W),
    .DEPTH (FRAMES)
  ) u_rank_ram (
    .clk_i   (clk_i),
    .we_i    (rank_we),
    .waddr_i (rd_idx_q),
    .wdata_i (rank_wdata),
    .re_i    (issue),
    .raddr_i (idx_q),
    .rdata_o (rank_rd)
  );

  // lookup accumulator
  lpr_scan u_scan (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .clr_i   (accept),
    .en_i    (scan_en),
    .idx_i   (rd_idx_q),
    .valid_i (rd_frame_valid),
    .match_i (page_rd == page_q),
    .rank_i  (rank_rd),
    .page_i  (page_rd),
    .res_o   (scan_res)
  );

  // decision: valid bits, fault count and sweep controls
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      fault_q <= '0;
    end else if (state_q == ST_DECIDE && !scan_res.found) begin
      if (fault_q != '1) begin
        fault_q <= fault_q + FAULT_W'(1);
      end
      if (scan_res.empty) begin
        valid_q[scan_res.empty_idx] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_DECIDE) begin
      target_q   <= target_d;
      hit_q      <= scan_res.found;
      age_all_q  <= !scan_res.found && scan_res.empty;
      old_rank_q <= scan_res.found ? scan_res.found_rank : scan_res.victim_rank;
      ev_valid_q <= !scan_res.found && !scan_res.empty;
      ev_page_q  <= (!scan_res.found && !scan_res.empty) ? scan_res.victim_page : '0;
    end
  end

  // result strobe after the last rank write
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= (state_q == ST_UPD_LAST);
    end
  end

  assign done_o          = done_q;
  assign hit_o           = hit_q;
  assign frame_index_o   = target_q;
  assign evicted_valid_o = ev_valid_q;
  assign evicted_page_o  = ev_page_q;
  assign fault_count_o   = fault_q;

`ifndef SYNTH
  // a word is only delivered once the engine has gone idle
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result delivered while busy");

  // hit and eviction exclude each other, no page reported without eviction
  a_hit_evict: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !(hit_o && evicted_valid_o) && (evicted_valid_o || evicted_page_o == '0))
    else $error("inconsistent hit and eviction");

  // a fault that lands in an empty frame leaves that frame valid
  a_fill_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && !hit_o |-> valid_q[frame_index_o])
    else $error("filled frame not marked valid");

  // taking a word starts the scan
  a_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> state_q == ST_SCAN)
    else $error("start not taken");
`endif

endmodule

// ===== dv/tb_lru_page_replacement.sv =====
// ----------------------------------------------------------------------------
// tb_lru_page_replacement: self-checking bench for the LRU frame engine
// Starts with a short table of directed page references and limit changes:
// empty frames, zero and full-scale pages, the clamped limits, a lowered
// limit that hides frames and a raised limit that reveals them again. Then it
// runs random phases on working sets sized around the frame limit. Every
// result word is compared field by field against its typed table row or an in-bench LRU model.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_lru_page_replacement;
  import lpr_pkg::*;

  localparam int unsigned RUN_LIMIT      = 800000;
  localparam int unsigned PHASES         = 17;
  localparam int unsigned WORDS_PER_PHASE = 100;
  localparam int unsigned POOL_DEPTH     = 20;
  localparam int unsigned DRAIN_LIMIT    = 2000;
  localparam int unsigned PRINT_CAP      = 50;

  // one result word as the engine reports it
  typedef struct packed {
    logic                 hit;
    logic [IDX_W-1:0]     frame;
    logic                 ev_valid;
    logic [PAGE_BITS-1:0] ev_page;
    logic [FAULT_W-1:0]   faults;
  } lru_word_t;

  typedef enum logic {
    ROW_CFG,
    ROW_WORD
  } row_kind_e;

  // one line of the directed table
  typedef struct packed {
    row_kind_e            kind;
    logic [PAGE_BITS-1:0] value;
    logic                 typed;
    lru_word_t            want;
  } dir_row_t;

  logic                 clk_i              = 1'b0;
  logic                 rst_ni             = 1'b0;
  logic                 frames_in_use_we_i = 1'b0;
  logic [LIMIT_W-1:0]   frames_in_use_i    = '0;
  logic                 start              = 1'b0;
  logic [PAGE_BITS-1:0] page_number_i      = '0;
  logic                 busy;
  logic                 done_o;
  logic                 hit_o;
  logic [IDX_W-1:0]     frame_index_o;
  logic                 evicted_valid_o;
  logic [PAGE_BITS-1:0] evicted_page_o;
  logic [FAULT_W-1:0]   fault_count_o;

  // model state of the frame store
  logic [PAGE_BITS-1:0] res_page  [FRAMES];
  logic                 res_valid [FRAMES];
  logic [RANK_W-1:0]    res_rank  [FRAMES];
  logic [FAULT_W-1:0]   fault_tally;
  logic [LIMIT_W-1:0]   limit_reg;

  lru_word_t   pending_words [$];
  dir_row_t    dir_rows [$];
  int unsigned err_count   = 0;
  int unsigned cycle_count = 0;

  lru_page_replacement i_dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .frames_in_use_we_i (frames_in_use_we_i),
    .frames_in_use_i    (frames_in_use_i),
    .start              (start),
    .busy               (busy),
    .page_number_i      (page_number_i),
    .done_o             (done_o),
    .hit_o              (hit_o),
    .frame_index_o      (frame_index_o),
    .evicted_valid_o    (evicted_valid_o),
    .evicted_page_o     (evicted_page_o),
    .fault_count_o      (fault_count_o)
  );

  // clock
  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // run time guard
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= RUN_LIMIT) begin
      $display("lru_page_replacement verification failed");
      $finish;
    end
  end

  task automatic flag_mismatch(input string what, input logic [31:0] got,
                               input logic [31:0] want);
    if (err_count < PRINT_CAP) begin
      $display("mismatch at cycle %0d: %s got %0h want %0h", cycle_count, what, got, want);
    end
    err_count++;
  endtask

  // limit of zero acts as one, anything above the frame count as the frame count
  function automatic int unsigned clamp_limit(input logic [LIMIT_W-1:0] raw);
    int unsigned lim;
    lim = raw;
    if (lim == 0) lim = 1;
    if (lim > FRAMES) lim = FRAMES;
    return lim;
  endfunction

  // make frame f the youngest; valid frames younger than old_rank (or all) age
  function automatic void age_frames(input int f, input logic [RANK_W-1:0] old_rank,
                                     input bit age_all);
    for (int j = 0; j < FRAMES; j++) begin
      if (j != f && res_valid[j] && (age_all || res_rank[j] < old_rank)) begin
        res_rank[j] = res_rank[j] + 1'b1;
      end
    end
    res_rank[f] = '0;
  endfunction

  // lru lookup and replacement for one referenced page
  function automatic lru_word_t lru_lookup(input logic [PAGE_BITS-1:0] page);
    int unsigned       lim;
    int                found;
    int                empty;
    int                victim;
    int                tgt;
    logic [RANK_W-1:0] vrank;
    lru_word_t         w;
    lim    = clamp_limit(limit_reg);
    found  = -1;
    empty  = -1;
    victim = -1;
    vrank  = '0;
    w      = '0;
    for (int f = 0; f < lim; f++) begin
      if (res_valid[f]) begin
        if (found < 0 && res_page[f] == page) found = f;
        if (victim < 0 || res_rank[f] > vrank) begin
          victim = f;
          vrank  = res_rank[f];
        end
      end else if (empty < 0) begin
        empty = f;
      end
    end
    if (found >= 0) begin
      w.hit = 1'b1;
      tgt   = found;
      age_frames(tgt, res_rank[tgt], 1'b0);
    end else begin
      if (fault_tally != '1) fault_tally = fault_tally + 1'b1;
      if (empty >= 0) begin
        tgt            = empty;
        res_valid[tgt] = 1'b1;
        age_frames(tgt, '0, 1'b1);
      end else begin
        tgt        = victim;
        w.ev_valid = 1'b1;
        w.ev_page  = res_page[tgt];
        age_frames(tgt, res_rank[tgt], 1'b0);
      end
      res_page[tgt] = page;
    end
    w.frame  = tgt[IDX_W-1:0];
    w.faults = fault_tally;
    return w;
  endfunction

  // present one word, hold until taken, then queue what it should produce
  task automatic send_word(input logic [PAGE_BITS-1:0] page, input logic typed,
                           input lru_word_t want);
    lru_word_t w;
    start         <= 1'b1;
    page_number_i <= page;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    w = lru_lookup(page);
    pending_words.push_back(typed ? want : w);
  endtask

  // let the engine drain before touching the register
  task automatic wait_idle();
    start <= 1'b0;
    @(posedge clk_i);
    while (pending_words.size() != 0 || busy) @(posedge clk_i);
  endtask

  task automatic write_limit(input logic [LIMIT_W-1:0] value);
    frames_in_use_we_i <= 1'b1;
    frames_in_use_i    <= value;
    @(posedge clk_i);
    limit_reg           = value;
    frames_in_use_we_i <= 1'b0;
  endtask

  function automatic dir_row_t cfg_row(input logic [LIMIT_W-1:0] value);
    dir_row_t r;
    r       = '0;
    r.kind  = ROW_CFG;
    r.value = PAGE_BITS'(value);
    return r;
  endfunction

  function automatic dir_row_t word_row(input logic [PAGE_BITS-1:0] page);
    dir_row_t r;
    r       = '0;
    r.kind  = ROW_WORD;
    r.value = page;
    return r;
  endfunction

  function automatic dir_row_t typed_row(input logic [PAGE_BITS-1:0] page, input logic hit,
                                         input logic [IDX_W-1:0] frame, input logic evv,
                                         input logic [PAGE_BITS-1:0] evp,
                                         input logic [FAULT_W-1:0] faults);
    dir_row_t r;
    r       = word_row(page);
    r.typed = 1'b1;
    r.want  = '{hit: hit, frame: frame, ev_valid: evv, ev_page: evp, faults: faults};
    return r;
  endfunction

  // result checker: every strobed word against the oldest expectation
  always @(posedge clk_i) begin
    lru_word_t w;
    if (rst_ni && done_o) begin
      if (pending_words.size() == 0) begin
        flag_mismatch("unexpected word, frame", frame_index_o, '0);
      end else begin
        w = pending_words.pop_front();
        if (hit_o !== w.hit) flag_mismatch("hit", hit_o, w.hit);
        if (frame_index_o !== w.frame) flag_mismatch("frame_index", frame_index_o, w.frame);
        if (evicted_valid_o !== w.ev_valid)
          flag_mismatch("evicted_valid", evicted_valid_o, w.ev_valid);
        if (evicted_page_o !== w.ev_page)
          flag_mismatch("evicted_page", evicted_page_o, w.ev_page);
        if (fault_count_o !== w.faults) flag_mismatch("fault_count", fault_count_o, w.faults);
      end
    end
  end

  // stimulus
  initial begin
    logic [LIMIT_W-1:0]   phase_limit [PHASES];
    logic [PAGE_BITS-1:0] pool [POOL_DEPTH];
    logic [PAGE_BITS-1:0] page;
    int unsigned          ws;
    int unsigned          left;
    int unsigned          burst;
    int unsigned          gap;
    int unsigned          drain;
    bit                   gappy;

    // model after reset
    for (int f = 0; f < FRAMES; f++) begin
      res_page[f]  = '0;
      res_valid[f] = 1'b0;
      res_rank[f]  = '0;
    end
    fault_tally = '0;
    limit_reg   = LIMIT_RESET;

    // directed table: fill, hit, evict, clamped limits, hidden and revealed frames
    dir_rows.push_back(typed_row(16'h0000, 1'b0, 4'd0, 1'b0, 16'h0000, 32'd1));
    dir_rows.push_back(typed_row(16'hFFFF, 1'b0, 4'd1, 1'b0, 16'h0000, 32'd2));
    dir_rows.push_back(typed_row(16'h0000, 1'b1, 4'd0, 1'b0, 16'h0000, 32'd2));
    dir_rows.push_back(typed_row(16'h1234, 1'b0, 4'd2, 1'b0, 16'h0000, 32'd3));
    dir_rows.push_back(typed_row(16'h8000, 1'b0, 4'd1, 1'b1, 16'hFFFF, 32'd4));
    dir_rows.push_back(typed_row(16'hFFFF, 1'b0, 4'd0, 1'b1, 16'h0000, 32'd5));
    dir_rows.push_back(cfg_row(5'd0));
    dir_rows.push_back(typed_row(16'hFFFF, 1'b1, 4'd0, 1'b0, 16'h0000, 32'd5));
    dir_rows.push_back(typed_row(16'h0001, 1'b0, 4'd0, 1'b1, 16'hFFFF, 32'd6));
    dir_rows.push_back(typed_row(16'h8000, 1'b0, 4'd0, 1'b1, 16'h0001, 32'd7));
    dir_rows.push_back(cfg_row(5'd3));
    dir_rows.push_back(typed_row(16'h1234, 1'b1, 4'd2, 1'b0, 16'h0000, 32'd7));
    dir_rows.push_back(typed_row(16'h8000, 1'b1, 4'd0, 1'b0, 16'h0000, 32'd7));
    dir_rows.push_back(cfg_row(5'd31));
    dir_rows.push_back(typed_row(16'h4242, 1'b0, 4'd3, 1'b0, 16'h0000, 32'd8));
    dir_rows.push_back(word_row(16'h5555));
    dir_rows.push_back(word_row(16'hAAAA));
    dir_rows.push_back(word_row(16'h00FF));
    dir_rows.push_back(word_row(16'hFF00));
    dir_rows.push_back(word_row(16'h0F0F));
    dir_rows.push_back(word_row(16'hF0F0));
    dir_rows.push_back(word_row(16'h3333));
    dir_rows.push_back(word_row(16'hCCCC));
    dir_rows.push_back(word_row(16'h7FFF));
    dir_rows.push_back(word_row(16'h0002));
    dir_rows.push_back(word_row(16'h1000));
    dir_rows.push_back(word_row(16'hFFFE));
    dir_rows.push_back(typed_row(16'h9999, 1'b0, 4'd1, 1'b1, 16'h8000, 32'd21));

    // limits per random phase: extremes, clamped values, lowering and raising
    phase_limit = '{5'd1, 5'd16, 5'd0, 5'd31, 5'd17, 5'd2, 5'd8, 5'd16, 5'd4,
                    5'd1, 5'd12, 5'd3, 5'd20, 5'd15, 5'd5, 5'd10, 5'd6};
    for (int p = 13; p < PHASES; p++) phase_limit[p] = LIMIT_W'($urandom_range(0, 31));

    // reset
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_CFG) begin
        wait_idle();
        write_limit(dir_rows[i].value[LIMIT_W-1:0]);
      end else begin
        send_word(dir_rows[i].value, dir_rows[i].typed, dir_rows[i].want);
      end
    end

    // random phases: mostly a working set near the frame limit, some stray pages
    for (int p = 0; p < PHASES; p++) begin
      wait_idle();
      write_limit(phase_limit[p]);
      ws = $urandom_range(1, clamp_limit(phase_limit[p]) + 4);
      for (int k = 0; k < POOL_DEPTH; k++) pool[k] = PAGE_BITS'($urandom_range(0, 65535));
      gappy = (p % 4) != 0;
      left  = WORDS_PER_PHASE;
      while (left > 0) begin
        burst = $urandom_range(1, 24);
        for (int k = 0; k < burst && left > 0; k++) begin
          if ($urandom_range(0, 99) < 85) page = pool[$urandom_range(0, ws - 1)];
          else page = PAGE_BITS'($urandom_range(0, 65535));
          send_word(page, 1'b0, '0);
          left--;
        end
        if (gappy) begin
          gap = $urandom_range(0, 48);
          if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge clk_i);
          end
        end
      end
    end

    // drain and settle
    start <= 1'b0;
    drain = 0;
    while (pending_words.size() != 0 && drain < DRAIN_LIMIT) begin
      @(posedge clk_i);
      drain++;
    end
    repeat (40) @(posedge clk_i);
    if (pending_words.size() != 0) flag_mismatch("words never seen", pending_words.size(), 0);

    if (err_count == 0) begin
      $display("lru_page_replacement verification clean");
    end else begin
      $display("lru_page_replacement verification failed");
    end
    $finish;
  end

endmodule
